// ===== rtl/bcst_pkg.sv =====
`default_nettype none

package bcst_pkg;

   // Field widths
   localparam int MV_W   = 13;
   localparam int HYST_W = 10;
   localparam int PCT_W  = 7;
   localparam int TIME_W = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Interpolation dividend: millivolt offset times percent span
   localparam int NUM_W = MV_W + PCT_W;

   // LFP open-circuit curve, millivolts against percent
   localparam int CURVE_POINTS = 7;
   localparam logic [MV_W-1:0] CURVE_MV [CURVE_POINTS] =
      '{13'd3000, 13'd3100, 13'd3200, 13'd3250, 13'd3300, 13'd3330, 13'd3400};
   localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_POINTS] =
      '{7'd0, 7'd6, 7'd10, 7'd25, 7'd55, 7'd75, 7'd100};
   localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ABSENT    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CRITICAL  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WARNING   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HYST      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_NEW_PACK  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_RECHARGE  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_MAX  = 3'd7;

   // Result codes
   typedef enum logic [1:0] {
      SRC_BATTERY  = 2'd0,
      SRC_EXTERNAL = 2'd1,
      SRC_NO_CELL  = 2'd2
   } source_type;

   typedef enum logic [1:0] {
      CHG_UNKNOWN  = 2'd0,
      CHG_IDLE     = 2'd1,
      CHG_CHARGING = 2'd2,
      CHG_FULL     = 2'd3
   } charge_type;

   typedef enum logic [1:0] {
      LVL_OK       = 2'd0,
      LVL_WARNING  = 2'd1,
      LVL_CRITICAL = 2'd2
   } level_type;

   typedef enum logic [1:0] {
      FLT_NONE        = 2'd0,
      FLT_RECOVERABLE = 2'd1,
      FLT_LATCHED     = 2'd2
   } fault_type;

   // Divider request and response
   typedef struct packed {
      logic             go;
      logic [NUM_W-1:0] dividend;
      logic [MV_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [NUM_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

// ===== rtl/bcst_div.sv =====
`default_nettype none

module bcst_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire bcst_pkg::div_req_type div_req,
   output bcst_pkg::div_rsp_type     div_rsp
);
   import bcst_pkg::*;

   localparam int CNT_W = $clog2(NUM_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [MV_W-1:0]   rem_ff, rem_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [MV_W-1:0]   dvs_ff, dvs_in;

   logic [MV_W:0]     shifted;
   logic [MV_W:0]     diff;
   logic              ge;

   // One restoring step: bring down the next dividend bit, subtract if it fits
   assign shifted = {rem_ff, quo_ff[NUM_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign ge      = shifted >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (div_req.go) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[MV_W-1:0] : shifted[MV_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

`ifndef SYNTH
   // a step count never runs past the dividend width
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff <= CNT_W'(NUM_W - 1))
      else $error("divider step count out of range");
   // done follows only a busy cycle
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without work");
   // the quotient of a restoring step always leaves a remainder below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && dvs_ff != '0) |-> rem_ff < dvs_ff)
      else $error("divider remainder not below divisor");
`endif

endmodule

`default_nettype wire

// ===== rtl/battery_charge_status_tracker.sv =====
// Battery charge status tracker: takes one sample per beat (cell millivolts,
// external-supply flag, two readings each of the charger fault and charge
// pins, seconds timestamp) and returns one result beat with supply source,
// charge state, fault class, hysteretic battery level, state of charge in
// percent from a 7-point LFP curve, fresh-pack flag, full-charge hold flag and
// a one-shot charger timer-retry request. A sample whose percent lands inside
// a curve segment waits for the interpolation quotient from a single restoring
// divider that retires one bit per cycle over the 20-bit dividend; any other
// sample skips the divide step. A result waits in the output register while
// rsp_stall is high; the next sample is accepted once the sequencer has
// handed off its result. The user must write registers through the csr_ port
// between samples; the block does not enforce it. csr_ready is always high.
`default_nettype none

module battery_charge_status_tracker #(
   parameter int TIME_BITS = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // sample channel
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [bcst_pkg::MV_W-1:0]          req_battery_mv,
   input  wire logic                               req_external_power,
   input  wire logic                               req_fault_pin_first,
   input  wire logic                               req_fault_pin_second,
   input  wire logic                               req_charge_pin_first,
   input  wire logic                               req_charge_pin_second,
   input  wire logic [bcst_pkg::TIME_W-1:0]        req_now_seconds,
   // result channel
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [1:0]                              rsp_source,
   output logic [1:0]                              rsp_charge_state,
   output logic [1:0]                              rsp_battery_level,
   output logic [1:0]                              rsp_fault_class,
   output logic [bcst_pkg::PCT_W-1:0]              rsp_percent,
   output logic                                    rsp_fresh_pack,
   output logic                                    rsp_full_hold,
   output logic                                    rsp_retry_request,
   // register write channel
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [bcst_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [bcst_pkg::CSR_DATA_W-1:0]    csr_data
);
   import bcst_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_FIN  = 3'b100
   } seq_state_type;

   // Configuration registers
   logic [MV_W-1:0]   absent_ff, critical_ff, warning_ff, full_ff;
   logic [MV_W-1:0]   new_pack_ff, recharge_ff;
   logic [HYST_W-1:0] hyst_ff;
   logic [TIME_W-1:0] hold_max_ff;

   // Tracker state
   level_type            level_ff, level_in;
   logic [MV_W-1:0]      prev_mv_ff, prev_mv_in;
   logic                 prev_valid_ff, prev_valid_in;
   logic                 seen_chg_ff, seen_chg_in;
   logic                 hold_ff, hold_in;
   logic [TIME_BITS-1:0] hold_start_ff, hold_start_in;
   logic                 retry_done_ff, retry_done_in;

   // Sequencer and pending result
   seq_state_type    state_ff, state_in;
   source_type       res_src_ff;
   charge_type       res_cstate_ff;
   level_type        res_level_ff;
   fault_type        res_fault_ff;
   logic [PCT_W-1:0] res_pct_ff, res_pct_in;
   logic             res_fresh_ff, res_hold_ff, res_retry_ff;

   // Output register
   logic             rsp_valid_ff, rsp_valid_in;
   source_type       rsp_src_ff;
   charge_type       rsp_cstate_ff;
   level_type        rsp_level_ff;
   fault_type        rsp_fault_ff;
   logic [PCT_W-1:0] rsp_pct_ff;
   logic             rsp_fresh_ff, rsp_hold_ff, rsp_retry_ff;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic accept;
   logic out_free;

   // Sample decode
   logic             cell_present, flt, chg, stable, ext;
   logic             fresh, retry_fire, hold_end;
   source_type       src;
   fault_type        fault;
   charge_type       cstate;
   level_type        base_level, new_level;
   logic [MV_W:0]    warn_up, crit_up;
   logic [TIME_BITS-1:0] elapsed;
   logic             seen_mid, retry_mid;

   // Curve segment
   logic [MV_W-1:0]  seg_v0, seg_d;
   logic [PCT_W-1:0] seg_p0, seg_dp;
   logic [MV_W-1:0]  seg_off;
   logic [NUM_W-1:0] seg_prod;
   logic             need_div;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         absent_ff   <= 13'd2000;
         critical_ff <= 13'd3000;
         warning_ff  <= 13'd3150;
         hyst_ff     <= 10'd50;
         full_ff     <= 13'd3550;
         new_pack_ff <= 13'd3300;
         recharge_ff <= 13'd3350;
         hold_max_ff <= 32'd3600;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ABSENT:   absent_ff   <= csr_data[MV_W-1:0];
            CSR_CRITICAL: critical_ff <= csr_data[MV_W-1:0];
            CSR_WARNING:  warning_ff  <= csr_data[MV_W-1:0];
            CSR_HYST:     hyst_ff     <= csr_data[HYST_W-1:0];
            CSR_FULL:     full_ff     <= csr_data[MV_W-1:0];
            CSR_NEW_PACK: new_pack_ff <= csr_data[MV_W-1:0];
            CSR_RECHARGE: recharge_ff <= csr_data[MV_W-1:0];
            CSR_HOLD_MAX: hold_max_ff <= csr_data[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   // Pin and supply decode
   assign ext          = req_external_power;
   assign cell_present = req_battery_mv >= absent_ff;
   assign flt          = req_fault_pin_first && req_fault_pin_second;
   assign chg          = req_charge_pin_first && req_charge_pin_second;
   assign stable       = (req_charge_pin_first == req_charge_pin_second);
   assign warn_up      = {1'b0, warning_ff} + (MV_W+1)'(hyst_ff);
   assign crit_up      = {1'b0, critical_ff} + (MV_W+1)'(hyst_ff);
   assign elapsed      = req_now_seconds[TIME_BITS-1:0] - hold_start_ff;

   always_comb begin
      fault = FLT_NONE;
      if (flt) fault = chg ? FLT_LATCHED : FLT_RECOVERABLE;
      src = SRC_BATTERY;
      if (ext) src = cell_present ? SRC_EXTERNAL : SRC_NO_CELL;
   end

   // Status update: charge state, seen-charging and retry bookkeeping
   always_comb begin
      cstate    = CHG_UNKNOWN;
      seen_mid  = seen_chg_ff;
      retry_mid = retry_done_ff;
      if (!cell_present) begin
         seen_mid = 1'b0;
      end else if (!ext) begin
         cstate    = CHG_IDLE;
         seen_mid  = 1'b0;
         retry_mid = 1'b0;
      end else if (fault != FLT_NONE || !stable) begin
         cstate = CHG_IDLE;
      end else if (chg) begin
         cstate   = CHG_CHARGING;
         seen_mid = 1'b1;
      end else if (seen_chg_ff || hold_ff || req_battery_mv >= full_ff) begin
         cstate = CHG_FULL;
      end else begin
         cstate = CHG_IDLE;
      end
   end

   // Fresh pack and level hysteresis
   assign fresh = cell_present && prev_valid_ff && ({1'b0, prev_mv_ff} < warn_up) &&
                  (req_battery_mv >= new_pack_ff);
   assign base_level = fresh ? LVL_OK : level_ff;

   always_comb begin
      unique case (base_level)
         LVL_CRITICAL: begin
            if ({1'b0, req_battery_mv} >= warn_up)      new_level = LVL_OK;
            else if ({1'b0, req_battery_mv} >= crit_up) new_level = LVL_WARNING;
            else                                        new_level = LVL_CRITICAL;
         end
         LVL_WARNING: begin
            if (req_battery_mv < critical_ff)           new_level = LVL_CRITICAL;
            else if ({1'b0, req_battery_mv} >= warn_up) new_level = LVL_OK;
            else                                        new_level = LVL_WARNING;
         end
         default: begin
            if (req_battery_mv < critical_ff)           new_level = LVL_CRITICAL;
            else if (req_battery_mv < warning_ff)       new_level = LVL_WARNING;
            else                                        new_level = LVL_OK;
         end
      endcase
   end

   // Full-charge hold, then one-shot retry
   assign hold_end   = (req_battery_mv < recharge_ff) ||
                       (TIME_W'(elapsed) >= hold_max_ff);
   assign retry_fire = (src == SRC_EXTERNAL) && (fault == FLT_LATCHED) &&
                       (req_battery_mv < full_ff) && !retry_mid;

   always_comb begin
      hold_in       = hold_ff;
      hold_start_in = hold_start_ff;
      seen_chg_in   = seen_chg_ff;
      retry_done_in = retry_done_ff;
      prev_mv_in    = prev_mv_ff;
      prev_valid_in = prev_valid_ff;
      level_in      = level_ff;
      if (accept) begin
         seen_chg_in   = seen_mid;
         retry_done_in = retry_mid || retry_fire;
         prev_valid_in = cell_present;
         if (cell_present) begin
            prev_mv_in = req_battery_mv;
            level_in   = new_level;
         end
         priority if (src != SRC_EXTERNAL || fault != FLT_NONE) begin
            hold_in = 1'b0;
         end else if (hold_ff) begin
            if (hold_end) begin
               hold_in     = 1'b0;
               seen_chg_in = 1'b0;
            end
         end else if (cstate == CHG_FULL && seen_mid) begin
            hold_in       = 1'b1;
            hold_start_in = req_now_seconds[TIME_BITS-1:0];
         end
      end
   end

   // Curve segment lookup; the lowest point above the voltage wins
   always_comb begin
      seg_v0 = CURVE_MV[0];
      seg_d  = '0;
      seg_p0 = CURVE_PCT[0];
      seg_dp = '0;
      for (int i = CURVE_POINTS - 1; i >= 1; i--) begin
         if (req_battery_mv < CURVE_MV[i]) begin
            seg_v0 = CURVE_MV[i-1];
            seg_d  = CURVE_MV[i] - CURVE_MV[i-1];
            seg_p0 = CURVE_PCT[i-1];
            seg_dp = CURVE_PCT[i] - CURVE_PCT[i-1];
         end
      end
   end

   assign seg_off  = req_battery_mv - seg_v0;
   assign seg_prod = NUM_W'(seg_off) * NUM_W'(seg_dp);

   // Percent before division; need_div marks an interior point of a segment
   always_comb begin
      res_pct_in = '0;
      need_div   = 1'b0;
      if (!cell_present) begin
         res_pct_in = '0;
      end else if (cstate == CHG_FULL) begin
         res_pct_in = PCT_FULL;
      end else if (req_battery_mv <= CURVE_MV[0]) begin
         res_pct_in = '0;
      end else if (req_battery_mv >= CURVE_MV[CURVE_POINTS-1]) begin
         res_pct_in = CURVE_PCT[CURVE_POINTS-1];
      end else begin
         res_pct_in = seg_p0;
         need_div   = (seg_d != '0);
      end
   end

   assign div_req.go       = accept && need_div;
   assign div_req.dividend = seg_prod;
   assign div_req.divisor  = seg_d;

   bcst_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = need_div ? ST_DIV : ST_FIN;
         ST_DIV:  if (div_rsp.done) state_in = ST_FIN;
         ST_FIN:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == ST_FIN && out_free) rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         level_ff      <= LVL_OK;
         prev_mv_ff    <= '0;
         prev_valid_ff <= 1'b0;
         seen_chg_ff   <= 1'b0;
         hold_ff       <= 1'b0;
         hold_start_ff <= '0;
         retry_done_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         level_ff      <= level_in;
         prev_mv_ff    <= prev_mv_in;
         prev_valid_ff <= prev_valid_in;
         seen_chg_ff   <= seen_chg_in;
         hold_ff       <= hold_in;
         hold_start_ff <= hold_start_in;
         retry_done_ff <= retry_done_in;
      end
   end

   // Pending result and output register
   always_ff @(posedge clock) begin
      if (accept) begin
         res_src_ff    <= src;
         res_cstate_ff <= cstate;
         res_level_ff  <= cell_present ? new_level : LVL_OK;
         res_fault_ff  <= fault;
         res_pct_ff    <= res_pct_in;
         res_fresh_ff  <= fresh;
         res_hold_ff   <= hold_in;
         res_retry_ff  <= retry_fire;
      end else if (state_ff == ST_DIV && div_rsp.done) begin
         res_pct_ff <= res_pct_ff + div_rsp.quotient[PCT_W-1:0];
      end
      if (state_ff == ST_FIN && out_free) begin
         rsp_src_ff    <= res_src_ff;
         rsp_cstate_ff <= res_cstate_ff;
         rsp_level_ff  <= res_level_ff;
         rsp_fault_ff  <= res_fault_ff;
         rsp_pct_ff    <= res_pct_ff;
         rsp_fresh_ff  <= res_fresh_ff;
         rsp_hold_ff   <= res_hold_ff;
         rsp_retry_ff  <= res_retry_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_source        = rsp_src_ff;
   assign rsp_charge_state  = rsp_cstate_ff;
   assign rsp_battery_level = rsp_level_ff;
   assign rsp_fault_class   = rsp_fault_ff;
   assign rsp_percent       = rsp_pct_ff;
   assign rsp_fresh_pack    = rsp_fresh_ff;
   assign rsp_full_hold     = rsp_hold_ff;
   assign rsp_retry_request = rsp_retry_ff;

`ifndef SYNTH
   // hold only runs with a cell seen on the last sample
   a_hold_needs_cell: assert property (@(posedge clock) disable iff (reset)
      hold_ff |-> prev_valid_ff)
      else $error("full hold active without a cell");
   // a retry request latches the one-shot
   a_retry_latch: assert property (@(posedge clock) disable iff (reset)
      (accept && retry_fire) |=> retry_done_ff)
      else $error("retry request did not latch");
   // the divider answers only while the sequencer waits for it
   a_div_in_step: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == ST_DIV)
      else $error("divider result outside the divide step");
   // interpolated percent never passes full scale
   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_pct_ff <= PCT_FULL)
      else $error("percent above full scale");
`endif

endmodule

`default_nettype wire

// ===== test/bcst_status_checker.sv =====
`default_nettype none

// Watches the sample, result and register channels of the tracker, keeps its
// own copy of the tracker state, and checks every result beat in order.
module bcst_status_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   input  wire logic                            req_stall,
   input  wire logic [bcst_pkg::MV_W-1:0]       req_battery_mv,
   input  wire logic                            req_external_power,
   input  wire logic                            req_fault_pin_first,
   input  wire logic                            req_fault_pin_second,
   input  wire logic                            req_charge_pin_first,
   input  wire logic                            req_charge_pin_second,
   input  wire logic [bcst_pkg::TIME_W-1:0]     req_now_seconds,
   input  wire logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   input  wire logic [1:0]                      rsp_source,
   input  wire logic [1:0]                      rsp_charge_state,
   input  wire logic [1:0]                      rsp_battery_level,
   input  wire logic [1:0]                      rsp_fault_class,
   input  wire logic [bcst_pkg::PCT_W-1:0]      rsp_percent,
   input  wire logic                            rsp_fresh_pack,
   input  wire logic                            rsp_full_hold,
   input  wire logic                            rsp_retry_request,
   input  wire logic                            csr_valid,
   input  wire logic                            csr_ready,
   input  wire logic [bcst_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [bcst_pkg::CSR_DATA_W-1:0] csr_data,
   output int                                   outstanding,
   output int                                   fail_count
);

   timeunit 1ns;
   timeprecision 1ps;

   import bcst_pkg::*;

   // LFP open-circuit curve
   localparam int OCV_POINTS = 7;
   localparam int OCV_MV [OCV_POINTS] = '{3000, 3100, 3200, 3250, 3300, 3330, 3400};
   localparam int OCV_PCT [OCV_POINTS] = '{0, 6, 10, 25, 55, 75, 100};

   typedef struct packed {
      source_type       src;
      charge_type       chg;
      level_type        lvl;
      fault_type        flt;
      logic [PCT_W-1:0] pct;
      logic             fresh;
      logic             hold;
      logic             retry;
   } status_type;

   // threshold registers
   logic [MV_W-1:0]   absent_cfg, crit_cfg, warn_cfg, full_cfg, fresh_cfg, recharge_cfg;
   logic [HYST_W-1:0] hyst_cfg;
   logic [TIME_W-1:0] hold_max_cfg;

   // tracker state
   level_type         level_q;
   logic [MV_W-1:0]   prev_mv_q;
   logic              prev_ok_q, charged_q, hold_q, retried_q;
   logic [TIME_W-1:0] hold_t0_q;

   status_type status_due[$];
   int      mismatches = 0;
   int      beat_no = 0;

   assign fail_count = mismatches;
   initial outstanding = 0;

   // percent from the curve, truncated
   function automatic logic [PCT_W-1:0] soc_percent(input logic [MV_W-1:0] v);
      int seg;
      int pct;
      pct = OCV_PCT[OCV_POINTS-1];
      if (int'(v) <= OCV_MV[0]) begin
         pct = 0;
      end else if (int'(v) < OCV_MV[OCV_POINTS-1]) begin
         // walk down so the lowest enclosing segment wins
         for (seg = OCV_POINTS - 1; seg >= 1; seg--) begin
            if (int'(v) < OCV_MV[seg]) begin
               pct = OCV_PCT[seg-1] + ((int'(v) - OCV_MV[seg-1]) *
                     (OCV_PCT[seg] - OCV_PCT[seg-1])) / (OCV_MV[seg] - OCV_MV[seg-1]);
            end
         end
      end
      return pct[PCT_W-1:0];
   endfunction

   // level with hysteresis on the way up
   function automatic level_type step_level(input level_type prior, input logic [MV_W-1:0] v);
      int mv;
      int warn_rise;
      int crit_rise;
      mv = int'(v);
      warn_rise = int'(warn_cfg) + int'(hyst_cfg);
      crit_rise = int'(crit_cfg) + int'(hyst_cfg);
      case (prior)
         LVL_CRITICAL: begin
            if (mv >= warn_rise) return LVL_OK;
            if (mv >= crit_rise) return LVL_WARNING;
            return LVL_CRITICAL;
         end
         LVL_WARNING: begin
            if (mv < int'(crit_cfg)) return LVL_CRITICAL;
            if (mv >= warn_rise) return LVL_OK;
            return LVL_WARNING;
         end
         default: begin
            if (mv < int'(crit_cfg)) return LVL_CRITICAL;
            if (mv < int'(warn_cfg)) return LVL_WARNING;
            return LVL_OK;
         end
      endcase
   endfunction

   // one sample: status update, then hold, then retry
   task automatic advance_tracker(input logic [MV_W-1:0] mv, input logic ext,
                                  input logic f0, input logic f1, input logic c0,
                                  input logic c1, input logic [TIME_W-1:0] now,
                                  output status_type st);
      logic cell_present, flt, chg, stable;
      cell_present = mv >= absent_cfg;
      flt    = f0 && f1;
      chg    = c0 && c1;
      stable = c0 == c1;
      st.src   = SRC_BATTERY;
      st.chg   = CHG_UNKNOWN;
      st.lvl   = LVL_OK;
      st.flt   = FLT_NONE;
      st.pct   = '0;
      st.fresh = 1'b0;
      st.hold  = 1'b0;
      st.retry = 1'b0;

      if (flt) st.flt = chg ? FLT_LATCHED : FLT_RECOVERABLE;
      if (ext) st.src = cell_present ? SRC_EXTERNAL : SRC_NO_CELL;

      if (!cell_present) begin
         // no cell: level is kept, history dropped
         prev_ok_q = 1'b0;
         charged_q = 1'b0;
      end else begin
         if (!ext) begin
            st.chg = CHG_IDLE;
            charged_q = 1'b0;
            retried_q = 1'b0;
         end else if (st.flt != FLT_NONE || !stable) begin
            st.chg = CHG_IDLE;
         end else if (chg) begin
            st.chg = CHG_CHARGING;
            charged_q = 1'b1;
         end else if (charged_q || hold_q || mv >= full_cfg) begin
            st.chg = CHG_FULL;
         end else begin
            st.chg = CHG_IDLE;
         end
         st.fresh = prev_ok_q && (int'(prev_mv_q) < int'(warn_cfg) + int'(hyst_cfg)) &&
                    mv >= fresh_cfg;
         prev_mv_q = mv;
         prev_ok_q = 1'b1;
         level_q = step_level(st.fresh ? LVL_OK : level_q, mv);
         st.lvl = level_q;
         st.pct = (st.chg == CHG_FULL) ? PCT_FULL : soc_percent(mv);
      end

      // full-charge hold
      if (st.src != SRC_EXTERNAL || st.flt != FLT_NONE) begin
         hold_q = 1'b0;
      end else if (hold_q) begin
         if (mv < recharge_cfg || TIME_W'(now - hold_t0_q) >= hold_max_cfg) begin
            hold_q = 1'b0;
            charged_q = 1'b0;
         end
      end else if (st.chg == CHG_FULL && charged_q) begin
         hold_q = 1'b1;
         hold_t0_q = now;
      end
      st.hold = hold_q;

      // one-shot timer retry
      if (st.src == SRC_EXTERNAL && st.flt == FLT_LATCHED && mv < full_cfg && !retried_q) begin
         retried_q = 1'b1;
         st.retry = 1'b1;
      end
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("result beat %0d: %s expected %0d, got %0d", beat_no, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      status_type head;
      status_type fresh_due;
      if (reset) begin
         absent_cfg   = 13'd2000;
         crit_cfg     = 13'd3000;
         warn_cfg     = 13'd3150;
         hyst_cfg     = 10'd50;
         full_cfg     = 13'd3550;
         fresh_cfg    = 13'd3300;
         recharge_cfg = 13'd3350;
         hold_max_cfg = 32'd3600;
         level_q   = LVL_OK;
         prev_mv_q = '0;
         prev_ok_q = 1'b0;
         charged_q = 1'b0;
         hold_q    = 1'b0;
         hold_t0_q = '0;
         retried_q = 1'b0;
         status_due.delete();
      end else begin
         // register write beat
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ABSENT:   absent_cfg   = csr_data[MV_W-1:0];
               CSR_CRITICAL: crit_cfg     = csr_data[MV_W-1:0];
               CSR_WARNING:  warn_cfg     = csr_data[MV_W-1:0];
               CSR_HYST:     hyst_cfg     = csr_data[HYST_W-1:0];
               CSR_FULL:     full_cfg     = csr_data[MV_W-1:0];
               CSR_NEW_PACK: fresh_cfg    = csr_data[MV_W-1:0];
               CSR_RECHARGE: recharge_cfg = csr_data[MV_W-1:0];
               CSR_HOLD_MAX: hold_max_cfg = csr_data[TIME_W-1:0];
               default: ;
            endcase
         end
         // result beat against the oldest expectation
         if (rsp_valid && !rsp_stall) begin
            beat_no++;
            if (status_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result beat %0d: no result expected", beat_no);
            end else begin
               head = status_due.pop_front();
               compare_field("source", head.src, rsp_source);
               compare_field("charge_state", head.chg, rsp_charge_state);
               compare_field("battery_level", head.lvl, rsp_battery_level);
               compare_field("fault_class", head.flt, rsp_fault_class);
               compare_field("percent", head.pct, rsp_percent);
               compare_field("fresh_pack", head.fresh, rsp_fresh_pack);
               compare_field("full_hold", head.hold, rsp_full_hold);
               compare_field("retry_request", head.retry, rsp_retry_request);
            end
         end
         // sample beat
         if (req_valid && !req_stall) begin
            advance_tracker(req_battery_mv, req_external_power, req_fault_pin_first,
                            req_fault_pin_second, req_charge_pin_first,
                            req_charge_pin_second, req_now_seconds, fresh_due);
            status_due.push_back(fresh_due);
         end
      end
      outstanding <= status_due.size();
   end

endmodule

`default_nettype wire

// ===== test/tb_battery_charge_status_tracker.sv =====
`default_nettype none

module tb_battery_charge_status_tracker;

   timeunit 1ns;
   timeprecision 1ps;

   import bcst_pkg::*;

   typedef enum {RUN_DRAIN, RUN_CHARGE, RUN_TOPPED, RUN_FAULT, RUN_SWAP, RUN_NOISE} run_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [MV_W-1:0]       req_battery_mv = '0;
   logic                  req_external_power = 1'b0;
   logic                  req_fault_pin_first = 1'b0;
   logic                  req_fault_pin_second = 1'b0;
   logic                  req_charge_pin_first = 1'b0;
   logic                  req_charge_pin_second = 1'b0;
   logic [TIME_W-1:0]     req_now_seconds = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [1:0]            rsp_source;
   logic [1:0]            rsp_charge_state;
   logic [1:0]            rsp_battery_level;
   logic [1:0]            rsp_fault_class;
   logic [PCT_W-1:0]      rsp_percent;
   logic                  rsp_fresh_pack;
   logic                  rsp_full_hold;
   logic                  rsp_retry_request;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   int                    outstanding;
   int                    fail_count;

   // idling controls, changed per phase
   int send_gap_pct = 0;
   int stall_pct = 0;

   // random sample generator state
   run_mode_type      run_mode = RUN_DRAIN;
   int                run_left = 0;
   int                gen_mv = 3400;
   logic [TIME_W-1:0] gen_now = 32'hFFFF_FC00;

   battery_charge_status_tracker dut (.*);

   bcst_status_checker checker_i (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // result side back-pressure
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // hold one sample beat until it is taken
   task automatic send_sample(input logic [MV_W-1:0] mv, input logic ext, input logic f0,
                              input logic f1, input logic c0, input logic c1,
                              input logic [TIME_W-1:0] now);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_battery_mv        <= mv;
      req_external_power    <= ext;
      req_fault_pin_first   <= f0;
      req_fault_pin_second  <= f1;
      req_charge_pin_first  <= c0;
      req_charge_pin_second <= c1;
      req_now_seconds       <= now;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // stop sending and wait for every result beat to come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic program_thresholds(input int setting);
      logic [CSR_DATA_W-1:0] absent, critical, warning, hyst, full, fresh, recharge, hold;
      // defaults unless a setting says otherwise
      absent = 2000; critical = 3000; warning = 3150; hyst = 50;
      full = 3550; fresh = 3300; recharge = 3350; hold = 3600;
      case (setting)
         2: begin
            absent = 0; critical = 0; warning = 0; hyst = 0;
            full = 0; fresh = 0; recharge = 0; hold = 0;
         end
         3: begin
            absent = 5000; critical = 5000; warning = 5000; hyst = 1000;
            full = 5000; fresh = 5000; recharge = 5000; hold = 32'hFFFF_FFFF;
         end
         4: begin
            absent   = $urandom_range(0, 5000);
            critical = $urandom_range(0, 5000);
            warning  = $urandom_range(0, 5000);
            hyst     = $urandom_range(0, 1000);
            full     = $urandom_range(0, 5000);
            fresh    = $urandom_range(0, 5000);
            recharge = $urandom_range(0, 5000);
            hold     = $urandom_range(0, 2000);
         end
         5: begin
            absent = 2500; critical = 3100; warning = 3250; hyst = 1000;
            full = 3400; fresh = 3200; recharge = 3300; hold = 100;
         end
         6: begin
            // plausible but shuffled thresholds
            absent   = $urandom_range(1500, 2900);
            critical = $urandom_range(2900, 3100);
            warning  = $urandom_range(3100, 3300);
            hyst     = $urandom_range(0, 200);
            full     = $urandom_range(3300, 3600);
            fresh    = $urandom_range(3200, 3400);
            recharge = $urandom_range(3250, 3450);
            hold     = $urandom_range(0, 5000);
         end
         7: begin
            hyst = 0;
            hold = 1;
         end
         default: ;
      endcase
      write_csr(CSR_ABSENT, absent);
      write_csr(CSR_CRITICAL, critical);
      write_csr(CSR_WARNING, warning);
      write_csr(CSR_HYST, hyst);
      write_csr(CSR_FULL, full);
      write_csr(CSR_NEW_PACK, fresh);
      write_csr(CSR_RECHARGE, recharge);
      write_csr(CSR_HOLD_MAX, hold);
      csr_valid <= 1'b0;
   endtask

   // hand-picked samples under the reset thresholds
   task automatic run_directed();
      int walk [11] = '{3400, 3330, 3315, 3300, 3275, 3250, 3200, 3150, 3100, 3000, 2999};
      int k;
      send_sample(13'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0);          // no cell, battery
      send_sample(13'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 32'd1);          // supply, no cell
      send_sample(13'd5000, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF); // latched, top mv
      // walk the curve points downward through warning into critical
      for (k = 0; k < 11; k++)
         send_sample(walk[k][MV_W-1:0], 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd10 + k);
      send_sample(13'd3330, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd50);      // fresh pack
      send_sample(13'd3400, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 32'd100);     // charging
      send_sample(13'd3450, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 32'd200);     // full, hold starts
      send_sample(13'd3450, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 32'd3800);    // hold runs out
      send_sample(13'd3450, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 32'd3801);    // charger probing
      send_sample(13'd3200, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 32'd3802);    // recoverable fault
      send_sample(13'd3200, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 32'd3803);    // latched, retry
      send_sample(13'd3200, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 32'd3804);    // no second retry
      send_sample(13'd3200, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 32'd3805);    // one fault reading
      send_sample(13'd3500, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd3806);    // back on battery
   endtask

   // runs of well-formed charge cycles with some noise mixed in
   task automatic next_random_sample();
      logic ext, f0, f1, c0, c1;
      int   pick;
      if (run_left == 0) begin
         pick = $urandom_range(99);
         if (run_mode == RUN_CHARGE && pick < 75) run_mode = RUN_TOPPED;
         else if (pick < 22) run_mode = RUN_CHARGE;
         else if (pick < 40) run_mode = RUN_TOPPED;
         else if (pick < 60) run_mode = RUN_DRAIN;
         else if (pick < 74) run_mode = RUN_FAULT;
         else if (pick < 87) run_mode = RUN_SWAP;
         else run_mode = RUN_NOISE;
         run_left = $urandom_range(4, 20);
         if (gen_mv < 2800) gen_mv = $urandom_range(2900, 3500);
      end
      run_left--;
      ext = 1'b1;
      {f0, f1, c0, c1} = 4'b0000;
      case (run_mode)
         RUN_DRAIN: begin
            ext = ($urandom_range(9) == 0);
            gen_mv = gen_mv - int'($urandom_range(0, 40));
            if ($urandom_range(7) == 0) {f0, f1, c0, c1} = 4'($urandom);
            gen_now += $urandom_range(1, 60);
         end
         RUN_CHARGE: begin
            c0 = 1'b1;
            c1 = ($urandom_range(9) != 0);
            gen_mv = gen_mv + int'($urandom_range(0, 40));
            gen_now += $urandom_range(1, 300);
         end
         RUN_TOPPED: begin
            if ($urandom_range(5) == 0) {c0, c1} = 2'($urandom);
            gen_mv = ($urandom_range(7) == 0) ? int'($urandom_range(2900, 3400))
                                              : int'($urandom_range(3300, 3650));
            gen_now += ($urandom_range(7) == 0) ? $urandom : $urandom_range(0, 900);
         end
         RUN_FAULT: begin
            f0 = 1'b1;
            f1 = ($urandom_range(4) != 0);
            {c0, c1} = 2'($urandom);
            ext = ($urandom_range(7) != 0);
            gen_mv = gen_mv + int'($urandom_range(0, 60)) - 30;
            gen_now += $urandom_range(1, 100);
         end
         RUN_SWAP: begin
            // cell pulled, run low or a fresh one fitted, picked at random per sample
            ext = 1'($urandom);
            case ($urandom_range(2))
               0: gen_mv = $urandom_range(0, 2100);
               1: gen_mv = $urandom_range(2800, 3250);
               default: gen_mv = $urandom_range(3250, 3700);
            endcase
            if ($urandom_range(3) == 0) {f0, f1, c0, c1} = 4'($urandom);
            gen_now += $urandom_range(1, 100);
         end
         default: begin
            gen_mv = $urandom_range(0, 5000);
            {ext, f0, f1, c0, c1} = 5'($urandom);
            gen_now = $urandom;
         end
      endcase
      if (gen_mv < 0) gen_mv = 0;
      if (gen_mv > 5000) gen_mv = 5000;
      send_sample(gen_mv[MV_W-1:0], ext, f0, f1, c0, c1, gen_now);
   endtask

   initial begin
      int phase;
      int n;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin send_gap_pct = 0;  stall_pct = 0;  end
            1: begin send_gap_pct = 59; stall_pct = 0;  end
            2: begin send_gap_pct = 0;  stall_pct = 59; end
            default: begin send_gap_pct = 24; stall_pct = 24; end
         endcase
         if (phase == 0) begin
            run_directed();
         end else begin
            wait_drained();
            program_thresholds(phase);
         end
         for (n = 0; n < 160; n++) next_random_sample();
      end
      wait_drained();
      repeat (40) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // run limit
   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire
